@@ design/vara_pkg.sv @@
// ----------------------------------------------------------------------------
// vara_pkg: shared constants and types for the vector align rotation unit
// Fixed-point formats, cell payload structs and result case codes.
// ----------------------------------------------------------------------------
package vara_pkg;

  localparam int IN_WIDTH_DEF  = 16;
  localparam int FRAC_BITS_DEF = 14;
  localparam int WF            = 30;
  localparam int NORM_W        = WF + 1;
  localparam int SQ_W          = 64;
  localparam int ROOT_W        = 32;
  localparam int OUT_W         = 16;
  // unit latency: max, encode, shift, square, sum, root cells, prep, divide cells, sign
  localparam int UNIT_LAT      = 5 + ROOT_W + 1 + NORM_W + 1;

  typedef enum logic [1:0] {
    CASE_GENERAL  = 2'd0,
    CASE_PARALLEL = 2'd1,
    CASE_ANTI     = 2'd2,
    CASE_ZERO     = 2'd3
  } case_code_t;

  typedef struct packed {
    logic [SQ_W-1:0]             op;
    logic [SQ_W-1:0]             res;
    logic [2:0]                  neg;
    logic [2:0][NORM_W-1:0]      mag;
  } vara_sq_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [ROOT_W-1:0] den;
    logic [NORM_W-1:0] num;
    logic [NORM_W-1:0] quo;
    logic              neg;
  } vara_div_t;

endpackage

@@ design/vara_if.sv @@
// ----------------------------------------------------------------------------
// vara_if: beat channels of the vector align rotation unit
// Input channel carries two vectors, output channel one matrix and case code.
// ----------------------------------------------------------------------------
interface vara_in_if import vara_pkg::*; #(parameter int IN_WIDTH = IN_WIDTH_DEF);
  logic                       valid;
  logic                       ready;
  logic signed [IN_WIDTH-1:0] a_x;
  logic signed [IN_WIDTH-1:0] a_y;
  logic signed [IN_WIDTH-1:0] a_z;
  logic signed [IN_WIDTH-1:0] b_x;
  logic signed [IN_WIDTH-1:0] b_y;
  logic signed [IN_WIDTH-1:0] b_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface vara_out_if import vara_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] m00;
  logic signed [OUT_W-1:0] m01;
  logic signed [OUT_W-1:0] m02;
  logic signed [OUT_W-1:0] m10;
  logic signed [OUT_W-1:0] m11;
  logic signed [OUT_W-1:0] m12;
  logic signed [OUT_W-1:0] m20;
  logic signed [OUT_W-1:0] m21;
  logic signed [OUT_W-1:0] m22;
  logic [1:0]              case_code;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, case_code,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, case_code,
                  output ready);
endinterface

@@ design/vara_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// vara_sqrt_cell: one step of the digit-by-digit integer square root
// Resolves one root bit and hands the remainder on to the next cell.
// ----------------------------------------------------------------------------
module vara_sqrt_cell import vara_pkg::*; #(
  parameter int BIT_POS = SQ_W - 2
) (
  input  logic     clk,
  input  logic     en,
  input  vara_sq_t d_in,
  output vara_sq_t d_out
);

  logic [SQ_W-1:0] bitv;
  logic [SQ_W-1:0] trial;
  vara_sq_t        nxt;

  always_comb begin
    bitv  = SQ_W'(1) << BIT_POS;
    trial = d_in.res + bitv;
    nxt   = d_in;
    if (d_in.op >= trial) begin
      nxt.op  = d_in.op - trial;
      nxt.res = (d_in.res >> 1) + bitv;
    end else begin
      nxt.res = d_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
    end
  end

endmodule

@@ design/vara_div_cell.sv @@
// ----------------------------------------------------------------------------
// vara_div_cell: one restoring division step
// Brings down one numerator bit and resolves one quotient bit.
// ----------------------------------------------------------------------------
module vara_div_cell import vara_pkg::*; #(
  parameter int QBIT = NORM_W - 1
) (
  input  logic      clk,
  input  logic      en,
  input  vara_div_t d_in,
  output vara_div_t d_out
);

  logic [ROOT_W:0] trial;
  logic [ROOT_W:0] den_x;
  vara_div_t       nxt;

  always_comb begin
    trial = {d_in.rem, d_in.num[QBIT]};
    den_x = {1'b0, d_in.den};
    nxt   = d_in;
    if (trial >= den_x) begin
      nxt.rem       = ROOT_W'(trial - den_x);
      nxt.quo[QBIT] = 1'b1;
    end else begin
      nxt.rem = ROOT_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
    end
  end

endmodule

@@ design/vara_unit.sv @@
// ----------------------------------------------------------------------------
// vara_unit: unit vector of a sign/magnitude 3-vector in Q.30
// Normalize, sum of squares, root cell chain, then three divider cell chains.
// ----------------------------------------------------------------------------
module vara_unit import vara_pkg::*; #(
  parameter int MAG_W = IN_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [2:0][MAG_W-1:0]   mag_in,
  input  logic [2:0]              neg_in,
  output logic [2:0][ROOT_W-1:0]  unit_out
);

  localparam int PW     = (MAG_W > 1) ? $clog2(MAG_W) : 1;
  localparam int WIDE_W = MAG_W + NORM_W;
  localparam int NUM_W  = NORM_W + WF + 1;

  logic [2:0][MAG_W-1:0]    mag1, mag2;
  logic [2:0]               neg1, neg2, neg3, neg4;
  logic [MAG_W-1:0]         mx, mx1;
  logic [PW-1:0]            pos, pos2;
  logic [2:0][NORM_W-1:0]   norm, mag3, mag4;
  logic [2:0][2*NORM_W-1:0] sq4;
  logic [WIDE_W-1:0]        wide [3];
  logic [WIDE_W-1:0]        sh [3];
  logic [ROOT_W-1:0]        root;
  logic [NUM_W-1:0]         num_full [3];
  logic [ROOT_W-1:0]        qz [3];
  vara_sq_t                 sq_chain [ROOT_W+1];
  vara_div_t                div_chain [3][NORM_W+1];

  always_comb begin
    mx = mag_in[0];
    if (mag_in[1] > mx) mx = mag_in[1];
    if (mag_in[2] > mx) mx = mag_in[2];
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mx1[i]) pos = PW'(i);
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      wide[l] = WIDE_W'(mag2[l]);
      if (int'(pos2) >= WF) begin
        sh[l] = wide[l] >> (int'(pos2) - WF);
      end else begin
        sh[l] = wide[l] << (WF - int'(pos2));
      end
      norm[l] = sh[l][NORM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1 <= mag_in;
      neg1 <= neg_in;
      mx1  <= mx;
      mag2 <= mag1;
      neg2 <= neg1;
      pos2 <= pos;
      mag3 <= norm;
      neg3 <= neg2;
      for (int l = 0; l < 3; l++) begin
        sq4[l] <= mag3[l] * mag3[l];
      end
      mag4 <= mag3;
      neg4 <= neg3;
      sq_chain[0].op  <= SQ_W'(sq4[0]) + SQ_W'(sq4[1]) + SQ_W'(sq4[2]);
      sq_chain[0].res <= '0;
      sq_chain[0].neg <= neg4;
      sq_chain[0].mag <= mag4;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    vara_sqrt_cell #(.BIT_POS(SQ_W - 2 - 2 * k)) u_cell (
      .clk   (clk),
      .en    (en),
      .d_in  (sq_chain[k]),
      .d_out (sq_chain[k+1])
    );
  end

  assign root = sq_chain[ROOT_W].res[ROOT_W-1:0];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      num_full[l] = (NUM_W'(sq_chain[ROOT_W].mag[l]) << WF) + NUM_W'(root >> 1);
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    always_ff @(posedge clk) begin
      if (en) begin
        div_chain[l][0].rem <= ROOT_W'(num_full[l] >> NORM_W);
        div_chain[l][0].den <= root;
        div_chain[l][0].num <= num_full[l][NORM_W-1:0];
        div_chain[l][0].quo <= '0;
        div_chain[l][0].neg <= sq_chain[ROOT_W].neg[l];
      end
    end

    for (genvar k = 0; k < NORM_W; k++) begin : g_div
      vara_div_cell #(.QBIT(NORM_W - 1 - k)) u_cell (
        .clk   (clk),
        .en    (en),
        .d_in  (div_chain[l][k]),
        .d_out (div_chain[l][k+1])
      );
    end

    assign qz[l] = ROOT_W'(div_chain[l][NORM_W].quo);

    always_ff @(posedge clk) begin
      if (en) begin
        unit_out[l] <= div_chain[l][NORM_W].neg ? -qz[l] : qz[l];
      end
    end
  end

endmodule

@@ design/vector_align_rotation_3d_unit.sv @@
// ----------------------------------------------------------------------------
// vector_align_rotation_3d_unit: rotation matrix that turns vector a onto b
// Pipeline: input register, cross product, unit-vector cell chains, matrix
//   math, output register.
// Throughput: one beat per cycle when not stalled; root and divider cell chains are pipelined.
// Reset: clears the valid bits and side flags only; data registers are not reset.
// ----------------------------------------------------------------------------
module vector_align_rotation_3d_unit import vara_pkg::*; #(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  vara_in_if.sink   din,
  vara_out_if.source dout
);

  localparam int CW     = 34;
  localparam int PW2    = 2 * IN_WIDTH;
  localparam int SIDE_D = UNIT_LAT + 4;
  localparam logic signed [63:0]    ONE   = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [CW-1:0]  UNITY = CW'(64'sd1 <<< WF);
  localparam logic [OUT_W-1:0]      ID_POS = OUT_W'(ONE);
  localparam logic [OUT_W-1:0]      ID_NEG = OUT_W'(-ONE);

  typedef struct packed {
    logic valid;
    logic zero;
    logic pzero;
  } side_t;

  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] x, input int s);
    logic signed [63:0] h;
    if (s == 0) return x;
    h = 64'sd1 <<< (s - 1);
    if (x >= 0) return (x + h) >>> s;
    return -((-x + h) >>> s);
  endfunction

  logic                       en, load0;
  logic                       v0, v1, v2, vout;
  logic signed [IN_WIDTH-1:0] a0 [3];
  logic signed [IN_WIDTH-1:0] b0 [3];
  logic [2:0][IN_WIDTH-1:0]   amag1, bmag1, amag2, bmag2;
  logic [2:0]                 aneg1, bneg1, aneg2, bneg2, pneg2;
  logic                       zero1, zero2, pzero2;
  logic signed [PW2-1:0]      pa1 [3];
  logic signed [PW2-1:0]      pb1 [3];
  logic signed [PW2:0]        pd [3];
  logic [2:0][PW2-1:0]        pmag2;
  logic [2:0][ROOT_W-1:0]     u, w, e;
  side_t                      side_q [SIDE_D];
  logic signed [63:0]         dp1 [3];
  logic signed [63:0]         cx1 [3][2];
  logic signed [63:0]         ee1 [3][3];
  logic signed [CW-1:0]       c2, c3, c4;
  logic signed [CW-1:0]       vx2 [3];
  logic signed [CW-1:0]       v3 [3];
  logic signed [CW-1:0]       e2 [3][3];
  logic signed [CW-1:0]       omc;
  logic signed [63:0]         pm3 [3][3];
  logic signed [CW-1:0]       kv [3][3];
  logic signed [CW-1:0]       m4 [3][3];
  logic signed [63:0]         q5 [3][3];
  logic [OUT_W-1:0]           mo [3][3];
  logic [1:0]                 code;

  assign en        = !vout || dout.ready;
  assign load0     = en || !v0;
  assign din.ready = load0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (load0) begin
      v0 <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load0) begin
      a0[0] <= din.a_x;
      a0[1] <= din.a_y;
      a0[2] <= din.a_z;
      b0[0] <= din.b_x;
      b0[1] <= din.b_y;
      b0[2] <= din.b_z;
    end
  end

  // cross product, exact on the raw integers; also sign/magnitude split and zero-input flag
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        aneg1[i] <= a0[i][IN_WIDTH-1];
        bneg1[i] <= b0[i][IN_WIDTH-1];
        amag1[i] <= a0[i][IN_WIDTH-1] ? IN_WIDTH'(-a0[i]) : IN_WIDTH'(a0[i]);
        bmag1[i] <= b0[i][IN_WIDTH-1] ? IN_WIDTH'(-b0[i]) : IN_WIDTH'(b0[i]);
        pa1[i]   <= a0[(i+1)%3] * b0[(i+2)%3];
        pb1[i]   <= a0[(i+2)%3] * b0[(i+1)%3];
      end
      zero1 <= (a0[0] == '0 && a0[1] == '0 && a0[2] == '0) ||
               (b0[0] == '0 && b0[1] == '0 && b0[2] == '0);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pd[i] = pa1[i] - pb1[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pneg2[i] <= pd[i] < 0;
        pmag2[i] <= PW2'((pd[i] < 0) ? -pd[i] : pd[i]);
      end
      amag2  <= amag1;
      bmag2  <= bmag1;
      aneg2  <= aneg1;
      bneg2  <= bneg1;
      zero2  <= zero1;
      pzero2 <= (pa1[0] == pb1[0]) && (pa1[1] == pb1[1]) && (pa1[2] == pb1[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
      v2 <= v1;
    end
  end

  vara_unit #(.MAG_W(IN_WIDTH)) u_unit_a (
    .clk(clk), .en(en), .mag_in(amag2), .neg_in(aneg2), .unit_out(u)
  );
  vara_unit #(.MAG_W(IN_WIDTH)) u_unit_b (
    .clk(clk), .en(en), .mag_in(bmag2), .neg_in(bneg2), .unit_out(w)
  );
  vara_unit #(.MAG_W(PW2)) u_unit_p (
    .clk(clk), .en(en), .mag_in(pmag2), .neg_in(pneg2), .unit_out(e)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SIDE_D; k++) begin
        side_q[k] <= '0;
      end
    end else if (en) begin
      side_q[0] <= '{valid: v2, zero: zero2, pzero: pzero2};
      for (int k = 1; k < SIDE_D; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_comb begin
    omc = UNITY - c2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        kv[i][j] = (i == j) ? c3 : '0;
      end
    end
    kv[0][1] = v3[2];
    kv[0][2] = -v3[1];
    kv[1][0] = -v3[2];
    kv[1][2] = v3[0];
    kv[2][0] = v3[1];
    kv[2][1] = -v3[0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dp1[i]    <= $signed(u[i]) * $signed(w[i]);
        cx1[i][0] <= $signed(u[(i+1)%3]) * $signed(w[(i+2)%3]);
        cx1[i][1] <= $signed(u[(i+2)%3]) * $signed(w[(i+1)%3]);
        for (int j = 0; j < 3; j++) begin
          ee1[i][j] <= $signed(e[i]) * $signed(e[j]);
        end
      end
      c2 <= CW'(rnd_sh(dp1[0] + dp1[1] + dp1[2], WF));
      for (int i = 0; i < 3; i++) begin
        vx2[i] <= CW'(rnd_sh(cx1[i][0] - cx1[i][1], WF));
        for (int j = 0; j < 3; j++) begin
          e2[i][j] <= CW'(rnd_sh(ee1[i][j], WF));
        end
      end
      c3 <= c2;
      v3 <= vx2;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pm3[i][j] <= omc * e2[i][j];
        end
      end
      c4 <= c3;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m4[i][j] <= CW'(rnd_sh(pm3[i][j], WF) + kv[i][j]);
        end
      end
    end
  end

  always_comb begin
    code = CASE_GENERAL;
    if (side_q[SIDE_D-1].zero) begin
      code = CASE_ZERO;
    end else if (side_q[SIDE_D-1].pzero) begin
      code = (c4 > 0) ? CASE_PARALLEL : CASE_ANTI;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        q5[i][j] = rnd_sh(m4[i][j], WF - FRAC_BITS);
        if (q5[i][j] > ONE) q5[i][j] = ONE;
        if (q5[i][j] < -ONE) q5[i][j] = -ONE;
        case (code)
          CASE_GENERAL: mo[i][j] = q5[i][j][OUT_W-1:0];
          CASE_ANTI:    mo[i][j] = (i == j) ? ID_NEG : '0;
          default:      mo[i][j] = (i == j) ? ID_POS : '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= side_q[SIDE_D-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.m00       <= mo[0][0];
      dout.m01       <= mo[0][1];
      dout.m02       <= mo[0][2];
      dout.m10       <= mo[1][0];
      dout.m11       <= mo[1][1];
      dout.m12       <= mo[1][2];
      dout.m20       <= mo[2][0];
      dout.m21       <= mo[2][1];
      dout.m22       <= mo[2][2];
      dout.case_code <= code;
    end
  end

  assign dout.valid = vout;

  a_zero_ident: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.case_code == CASE_ZERO |->
      dout.m00 == ID_POS && dout.m11 == ID_POS && dout.m22 == ID_POS && dout.m01 == '0)
    else $error("zero-input beat is not identity");

  a_anti_ident: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.case_code == CASE_ANTI |->
      dout.m00 == ID_NEG && dout.m11 == ID_NEG && dout.m22 == ID_NEG && dout.m12 == '0)
    else $error("antiparallel beat is not negated identity");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(side_q[SIDE_D-1]) && $stable(m4[0][0]))
    else $error("pipeline moved while output stalled");

  a_in_to_side: assert property (@(posedge clk) disable iff (rst)
    en && v2 |=> side_q[0].valid)
    else $error("beat lost entering unit chain");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of vector_align_rotation_3d_unit
// Offers vector pairs, first from a directed table, then at random. Every
// output beat is checked, within one LSB, against a fixed-point model of the
// alignment matrix or the expected identity of a typed pair, with random gaps
// and stalls on both channels and one long output stall that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
  import vara_pkg::*;

  localparam int NDIR       = 16;
  localparam int NRAND      = 500;
  localparam int NTOT       = NDIR + NRAND;
  localparam int LIMIT      = 200000;
  localparam int DRAIN      = 120;
  localparam longint ONE    = 64'sd1 << FRAC_BITS_DEF;

  typedef longint vec3_t [3];
  typedef bit [63:0] uvec3_t [3];

  typedef struct {
    logic signed [15:0] m [9];
    case_code_t         code;
  } matrix_t;

  typedef struct {
    logic signed [15:0] a [3];
    logic signed [15:0] b [3];
    bit                 typed;
    matrix_t            exp;
  } pair_t;

  logic clk;
  logic rst;
  int   cycles;
  int   n_acc;
  int   n_out;
  int   n_err;
  int   n_case [4];
  bit   hold;
  int   phase;
  bit   done;

  matrix_t matrix_q [$];
  pair_t   stim [NTOT];

  vara_in_if #(.IN_WIDTH(IN_WIDTH_DEF)) din_if ();
  vara_out_if dout_if ();

  vector_align_rotation_3d_unit #(
    .IN_WIDTH (IN_WIDTH_DEF),
    .FRAC_BITS(FRAC_BITS_DEF)
  ) uut (
    .clk (clk),
    .rst (rst),
    .din (din_if),
    .dout(dout_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // rounding right shift, ties away from zero
  function automatic longint rshift_rnd(longint x, int s);
    longint h;
    h = 64'sd1 << (s - 1);
    if (x >= 0) return (x + h) >>> s;
    return -((-x + h) >>> s);
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] op);
    bit [63:0] res;
    bit [63:0] bt;
    res = 0;
    bt  = 64'd1 << 62;
    while (bt > op) bt = bt >> 2;
    while (bt != 0) begin
      if (op >= res + bt) begin
        op  = op - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic vec3_t unit_q30(bit [2:0] neg, uvec3_t magin);
    vec3_t     o;
    uvec3_t    mag;
    bit [63:0] m, s, r, q;
    o   = '{0, 0, 0};
    mag = magin;
    m   = mag[0];
    if (mag[1] > m) m = mag[1];
    if (mag[2] > m) m = mag[2];
    if (m == 0) return o;
    while (m >= (64'd1 << 31)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (m < (64'd1 << 30)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    r = int_sqrt(s);
    if (r == 0) return o;
    for (int i = 0; i < 3; i++) begin
      q    = ((mag[i] << WF) + (r >> 1)) / r;
      o[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return o;
  endfunction

  function automatic matrix_t ident(longint d, case_code_t code);
    matrix_t r;
    for (int i = 0; i < 9; i++) r.m[i] = (i % 4 == 0) ? 16'(d) : 16'sd0;
    r.code = code;
    return r;
  endfunction

  function automatic matrix_t align_matrix(pair_t p);
    longint    a [3], b [3], v [3], mm [3][3];
    vec3_t     u, w, e;
    uvec3_t    am, bm, pm;
    bit [2:0]  an, bn, pn;
    longint    c, omc, p1, p2, eij, q;
    int        j1, k1;
    matrix_t   r;
    for (int i = 0; i < 3; i++) begin
      a[i]  = p.a[i];
      b[i]  = p.b[i];
      an[i] = a[i] < 0;
      bn[i] = b[i] < 0;
      am[i] = an[i] ? -a[i] : a[i];
      bm[i] = bn[i] ? -b[i] : b[i];
    end
    if ((am[0] | am[1] | am[2]) == 0 || (bm[0] | bm[1] | bm[2]) == 0)
      return ident(ONE, CASE_ZERO);
    for (int i = 0; i < 3; i++) begin
      j1 = (i + 1) % 3;
      k1 = (i + 2) % 3;
      p1 = a[j1] * b[k1];
      p2 = a[k1] * b[j1];
      pn[i] = p1 < p2;
      pm[i] = (p1 >= p2) ? p1 - p2 : p2 - p1;
    end
    u = unit_q30(an, am);
    w = unit_q30(bn, bm);
    c = rshift_rnd(u[0] * w[0] + u[1] * w[1] + u[2] * w[2], WF);
    if ((pm[0] | pm[1] | pm[2]) == 0)
      return (c > 0) ? ident(ONE, CASE_PARALLEL) : ident(-ONE, CASE_ANTI);
    e = unit_q30(pn, pm);
    for (int i = 0; i < 3; i++) begin
      j1   = (i + 1) % 3;
      k1   = (i + 2) % 3;
      v[i] = rshift_rnd(u[j1] * w[k1] - u[k1] * w[j1], WF);
    end
    omc = (64'sd1 << WF) - c;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        eij      = rshift_rnd(e[i] * e[j], WF);
        mm[i][j] = rshift_rnd(omc * eij, WF) + ((i == j) ? c : 0);
      end
    mm[0][1] += v[2]; mm[0][2] -= v[1];
    mm[1][0] -= v[2]; mm[1][2] += v[0];
    mm[2][0] += v[1]; mm[2][1] -= v[0];
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        q = rshift_rnd(mm[i][j], WF - FRAC_BITS_DEF);
        if (q > ONE) q = ONE;
        if (q < -ONE) q = -ONE;
        r.m[i * 3 + j] = 16'(q);
      end
    r.code = CASE_GENERAL;
    return r;
  endfunction

  function automatic pair_t mk_pair(int ax, int ay, int az, int bx, int by, int bz);
    pair_t p;
    p.a   = '{16'(ax), 16'(ay), 16'(az)};
    p.b   = '{16'(bx), 16'(by), 16'(bz)};
    p.typed = 1'b0;
    p.exp   = ident(ONE, CASE_ZERO);
    return p;
  endfunction

  function automatic pair_t mk_typed(int ax, int ay, int az, int bx, int by, int bz,
                                     longint d, case_code_t code);
    pair_t p;
    p       = mk_pair(ax, ay, az, bx, by, bz);
    p.typed = 1'b1;
    p.exp   = ident(d, code);
    return p;
  endfunction

  function automatic int rnd_full();
    return int'($signed(16'($urandom)));
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int    sel, k, lo;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      p = mk_pair(rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full());
    end else if (sel < 75) begin
      p = mk_pair($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                  $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4);
    end else if (sel < 90) begin
      // scaled copies: parallel or antiparallel
      lo = $urandom_range(0, 1) ? 200 : 3;
      p  = mk_pair($urandom_range(0, 2 * lo) - lo, $urandom_range(0, 2 * lo) - lo,
                   $urandom_range(0, 2 * lo) - lo, 0, 0, 0);
      k  = $urandom_range(1, lo == 3 ? 9000 : 150);
      if ($urandom_range(0, 1)) k = -k;
      for (int i = 0; i < 3; i++) p.b[i] = 16'(int'(p.a[i]) * k);
    end else begin
      p = mk_pair(rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full());
      k = $urandom_range(0, 5);
      if (k < 3) p.a[k] = 0; else p.b[k - 3] = 0;
      if ($urandom_range(0, 3) == 0) p.a = '{0, 0, 0};
    end
    return p;
  endfunction

  initial begin
    stim[0]  = mk_typed(0, 0, 0, 1, 2, 3, ONE, CASE_ZERO);
    stim[1]  = mk_typed(1, 2, 3, 0, 0, 0, ONE, CASE_ZERO);
    stim[2]  = mk_typed(0, 0, 0, 0, 0, 0, ONE, CASE_ZERO);
    stim[3]  = mk_typed(5, 0, 0, 7, 0, 0, ONE, CASE_PARALLEL);
    stim[4]  = mk_typed(-32768, -32768, -32768, -1, -1, -1, ONE, CASE_PARALLEL);
    stim[5]  = mk_typed(32767, 0, 0, -32768, 0, 0, -ONE, CASE_ANTI);
    stim[6]  = mk_typed(1, -2, 3, -2, 4, -6, -ONE, CASE_ANTI);
    stim[7]  = mk_typed(32767, 32767, 32767, 32767, 32767, 32767, ONE, CASE_PARALLEL);
    stim[8]  = mk_pair(1, 0, 0, 0, 1, 0);
    stim[9]  = mk_pair(0, 0, 1, 1, 0, 0);
    stim[10] = mk_pair(32767, -32768, 32767, -32768, 32767, -32768);
    stim[11] = mk_pair(32767, 32766, 0, 32766, 32765, 0);
    stim[12] = mk_pair(-32768, 0, 0, 0, 0, 32767);
    stim[13] = mk_pair(-1, -1, -1, 1, 1, -1);
    stim[14] = mk_pair(1, 0, 0, -32768, 1, 0);
    stim[15] = mk_pair(-21846, 21845, -1, 1, 32767, -32768);
    for (int i = NDIR; i < NTOT; i++) stim[i] = rand_pair();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycles, matrix_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // source side
  initial begin
    pair_t p;
    int    idle_pct;
    bit    go;
    cycles = 0;
    n_acc  = 0;
    phase  = 0;
    done   = 1'b0;
    rst    = 1'b1;
    din_if.valid <= 1'b0;
    din_if.a_x <= '0; din_if.a_y <= '0; din_if.a_z <= '0;
    din_if.b_x <= '0; din_if.b_y <= '0; din_if.b_z <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (n_acc < NTOT) begin
      @(posedge clk);
      if (din_if.valid && din_if.ready) begin
        p = stim[n_acc];
        matrix_q.push_back(p.typed ? p.exp : align_matrix(p));
        n_acc++;
      end
      phase    = (n_acc < NDIR) ? 0 : ((n_acc - NDIR) / 125 > 3 ? 3 : (n_acc - NDIR) / 125);
      idle_pct = (phase == 1) ? 70 : (phase == 3) ? 18 : 0;
      if (!din_if.valid || din_if.ready) begin
        go = (n_acc < NTOT) && ($urandom_range(0, 99) >= idle_pct);
        din_if.valid <= go;
        if (go) begin
          p = stim[n_acc];
          din_if.a_x <= p.a[0]; din_if.a_y <= p.a[1]; din_if.a_z <= p.a[2];
          din_if.b_x <= p.b[0]; din_if.b_y <= p.b[1]; din_if.b_z <= p.b[2];
        end
      end
    end
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    done = 1'b1;
  end

  // long output hold-off to back up the pipeline
  initial begin
    hold = 1'b0;
    wait (n_acc >= NDIR + 20);
    @(posedge clk);
    hold = 1'b1;
    for (int i = 0; i < 250; i++) @(posedge clk);
    hold = 1'b0;
  end

  // sink side
  initial begin
    int stall_pct;
    dout_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      stall_pct = (phase == 2) ? 70 : (phase == 3) ? 18 : 0;
      dout_if.ready <= !rst && !hold && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    matrix_t got, want;
    bit      bad;
    int      d;
    if (!rst && dout_if.valid && dout_if.ready) begin
      got.m = '{dout_if.m00, dout_if.m01, dout_if.m02, dout_if.m10, dout_if.m11,
                dout_if.m12, dout_if.m20, dout_if.m21, dout_if.m22};
      got.code = case_code_t'(dout_if.case_code);
      n_out <= n_out + 1;
      if (matrix_q.size() == 0) begin
        n_err <= n_err + 1;
        if (n_err < 10) $display("unexpected output beat at cycle %0d", cycles);
      end else begin
        want = matrix_q.pop_front();
        n_case[want.code] <= n_case[want.code] + 1;
        bad = (got.code != want.code);
        // exact value may sit on a rounding tie: allow one LSB
        for (int i = 0; i < 9; i++) begin
          d = int'(got.m[i]) - int'(want.m[i]);
          if (d > 1 || d < -1 || $isunknown(got.m[i])) bad = 1'b1;
        end
        if (bad) begin
          n_err <= n_err + 1;
          if (n_err < 10)
            $display("mismatch beat %0d: exp %p, got %p", n_out, want, got);
        end
      end
    end
  end

  initial begin
    n_out  = 0;
    n_err  = 0;
    n_case = '{0, 0, 0, 0};
    wait (done);
    $display("%0d pairs in, %0d matrices out over %0d cycles", n_acc, n_out, cycles);
    $display("general %0d, parallel %0d, antiparallel %0d, zero input %0d",
             n_case[0], n_case[1], n_case[2], n_case[3]);
    if (n_err == 0 && matrix_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
